/* rtl/p1crc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p1crc_pkg
// Shared types, constants and helper functions for the P1 telegram CRC checker.
// ----------------------------------------------------------------------------
package p1crc_pkg;

    localparam logic [15:0] CRC_POLY_REFL  = 16'hA001;
    localparam logic [15:0] CRC_INIT       = 16'h0000;
    localparam logic [7:0]  START_CHAR     = 8'h2F;
    localparam logic [7:0]  END_CHAR       = 8'h21;
    localparam logic [2:0]  CLAIM_DIGITS   = 3'd4;
    localparam logic [15:0] MAX_LEN_RESET  = 16'd16384;

    typedef enum logic [1:0] {
        STAT_CRC_OK   = 2'd0,
        STAT_CRC_BAD  = 2'd1,
        STAT_OVERFLOW = 2'd2
    } frame_status_t;

    typedef struct packed {
        frame_status_t status;
        logic [15:0]   length;
        logic [15:0]   computed;
        logic [15:0]   claimed;
    } result_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] rx_byte;
    } staged_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } hex_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY_REFL;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    function automatic hex_t hex_value(input logic [7:0] c);
        hex_t h;
        h.ok    = 1'b1;
        h.value = c[3:0];
        if (c >= 8'h30 && c <= 8'h39)
            h.value = c[3:0];
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
            h.value = c[3:0] + 4'd9;
        else
            h.ok = 1'b0;
        return h;
    endfunction

endpackage

/* rtl/p1crc_byte_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p1crc_byte_if
// Valid/ready channel carrying one received serial byte per transaction.
// ----------------------------------------------------------------------------
interface p1crc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

/* rtl/p1crc_result_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p1crc_result_if
// Valid/ready channel carrying one frame check result per transaction.
// ----------------------------------------------------------------------------
interface p1crc_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  frame_status;
    logic [15:0] frame_length;
    logic [15:0] computed_crc;
    logic [15:0] claimed_crc;

    modport source (output valid, output frame_status, output frame_length,
                    output computed_crc, output claimed_crc, input ready);
    modport sink   (input valid, input frame_status, input frame_length,
                    input computed_crc, input claimed_crc, output ready);
endinterface

/* rtl/p1crc_in_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p1crc_in_stage
// Input register: captures one byte per transaction and holds it until the
// frame stage consumes it.
// ----------------------------------------------------------------------------
module p1crc_in_stage
    import p1crc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    p1crc_byte_if.sink in_ch,
    input  logic      advance,
    output staged_t   staged
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       take;

    assign take       = !valid_reg || advance;
    assign in_ch.ready = take;
    assign valid_next = take ? in_ch.valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take && in_ch.valid)
            byte_reg <= in_ch.rx_byte;
    end

    assign staged.valid   = valid_reg;
    assign staged.rx_byte = byte_reg;

endmodule

/* rtl/p1crc_frame.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p1crc_frame
// Frame tracker: start/end detection, CRC-16/ARC update, length limit, hex
// digit capture, and the result register.
// ----------------------------------------------------------------------------
module p1crc_frame
    import p1crc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_wr_en,
    input  logic [15:0]   cfg_wr_data,
    input  staged_t       staged,
    output logic          advance,
    p1crc_result_if.source out_ch
);

    logic [15:0] max_length_reg;
    logic        in_frame_reg,  in_frame_next;
    logic        reading_reg,   reading_next;
    logic [15:0] crc_reg,       crc_next;
    logic [15:0] count_reg,     count_next;
    logic [2:0]  digits_reg,    digits_next;
    logic [15:0] claimed_reg,   claimed_next;
    logic        hex_ended_reg, hex_ended_next;
    logic        out_valid_reg, out_valid_next;
    result_t     out_reg,       out_next;
    logic        emit;

    logic [7:0]  c;
    hex_t        hx;
    logic [15:0] crc_upd;
    logic [15:0] claim_upd;
    logic [2:0]  digits_upd;
    logic        room;

    assign advance   = staged.valid && (!out_valid_reg || out_ch.ready);
    assign c         = staged.rx_byte;
    assign hx        = hex_value(c);
    assign crc_upd   = crc_byte(crc_reg, c);
    assign claim_upd = (!hex_ended_reg && hx.ok) ? {claimed_reg[11:0], hx.value} : claimed_reg;
    assign digits_upd = digits_reg + 3'd1;
    assign room      = ({1'b0, count_reg} + 17'd1) < {1'b0, max_length_reg};

    always_comb
    begin
        in_frame_next  = in_frame_reg;
        reading_next   = reading_reg;
        crc_next       = crc_reg;
        count_next     = count_reg;
        digits_next    = digits_reg;
        claimed_next   = claimed_reg;
        hex_ended_next = hex_ended_reg;
        emit           = 1'b0;
        out_next       = out_reg;

        if (advance) begin
            if (reading_reg) begin
                claimed_next   = claim_upd;
                hex_ended_next = hex_ended_reg || !hx.ok;
                digits_next    = digits_upd;
                if (digits_upd >= CLAIM_DIGITS) begin
                    emit            = 1'b1;
                    out_next.status = (claim_upd == crc_reg) ? STAT_CRC_OK : STAT_CRC_BAD;
                    out_next.length   = count_reg;
                    out_next.computed = crc_reg;
                    out_next.claimed  = claim_upd;
                end
            end else if (in_frame_reg || c == START_CHAR) begin
                in_frame_next = 1'b1;
                if (c == END_CHAR) begin
                    crc_next       = crc_upd;
                    count_next     = count_reg + 16'd1;
                    reading_next   = 1'b1;
                    digits_next    = 3'd0;
                    claimed_next   = 16'd0;
                    hex_ended_next = 1'b0;
                end else if (room) begin
                    crc_next   = crc_upd;
                    count_next = count_reg + 16'd1;
                end else begin
                    emit              = 1'b1;
                    out_next.status   = STAT_OVERFLOW;
                    out_next.length   = count_reg;
                    out_next.computed = crc_reg;
                    out_next.claimed  = 16'd0;
                end
            end

            // any result closes the frame
            if (emit) begin
                in_frame_next  = 1'b0;
                reading_next   = 1'b0;
                crc_next       = CRC_INIT;
                count_next     = 16'd0;
                digits_next    = 3'd0;
                claimed_next   = 16'd0;
                hex_ended_next = 1'b0;
            end
        end

        if (emit)
            out_valid_next = 1'b1;
        else if (out_ch.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            max_length_reg <= MAX_LEN_RESET;
            in_frame_reg   <= 1'b0;
            reading_reg    <= 1'b0;
            crc_reg        <= CRC_INIT;
            count_reg      <= 16'd0;
            digits_reg     <= 3'd0;
            claimed_reg    <= 16'd0;
            hex_ended_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en)
                max_length_reg <= cfg_wr_data;
            in_frame_reg  <= in_frame_next;
            reading_reg   <= reading_next;
            crc_reg       <= crc_next;
            count_reg     <= count_next;
            digits_reg    <= digits_next;
            claimed_reg   <= claimed_next;
            hex_ended_reg <= hex_ended_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.frame_status = out_reg.status;
    assign out_ch.frame_length = out_reg.length;
    assign out_ch.computed_crc = out_reg.computed;
    assign out_ch.claimed_crc  = out_reg.claimed;

endmodule

/* rtl/p1_telegram_crc_checker_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p1_telegram_crc_checker_core
// Checks CRC-16/ARC of smart-meter P1 telegrams, one serial byte per transaction.
// ----------------------------------------------------------------------------
// Accepts one byte every clock cycle unless the input channel stalls. Each byte
// passes an input register and is folded into the frame state when the frame
// stage consumes it; a result, when the byte closes a frame (fourth character
// after '!' or a length overflow), is loaded into the result register as that
// byte is consumed. The CRC byte update is combinational between the input
// register and the state registers. The input channel stalls only while a
// finished result waits in the result register and a further byte is held.
// max_length may be written only while no frame is in flight.
module p1_telegram_crc_checker_core
    import p1crc_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_wr_en,
    input  logic [15:0]    cfg_wr_data,
    p1crc_byte_if.sink     in_ch,
    p1crc_result_if.source out_ch
);

    staged_t staged;
    logic    advance;

    p1crc_in_stage u_in_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .advance (advance),
        .staged  (staged)
    );

    p1crc_frame u_frame (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .staged      (staged),
        .advance     (advance),
        .out_ch      (out_ch)
    );

    a_new_result_needs_byte: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_ch.valid) |-> $past(advance))
        else $error("result appeared without a consumed byte");

    a_ok_means_match: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.frame_status == STAT_CRC_OK)
            |-> (out_ch.computed_crc == out_ch.claimed_crc))
        else $error("crc ok reported on mismatch");

    a_overflow_no_claim: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.frame_status == STAT_OVERFLOW) |-> (out_ch.claimed_crc == 16'd0))
        else $error("overflow result carries a claimed crc");

    a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (out_ch.frame_status == STAT_CRC_OK
            || out_ch.frame_status == STAT_CRC_BAD || out_ch.frame_status == STAT_OVERFLOW))
        else $error("illegal frame status");

endmodule
